@@ hdl/pc_pkg.sv @@
`default_nettype none
package pc_pkg;
    localparam int SampleBits  = 16;
    localparam int SampleLimit = 256;
    localparam int CntW        = 9;
    localparam int SumW        = 24;
    localparam int SqW         = 39;
    localparam int CfgIdxW     = 2;
    localparam int CfgDataW    = 16;

    localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
    localparam logic [CfgIdxW-1:0] RegMinVar    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegFullCount = 2'd2;

    typedef struct packed {
        logic signed [SampleBits-1:0] sample_a;
        logic signed [SampleBits-1:0] sample_b;
        logic [7:0] type_a;
        logic [7:0] type_b;
        logic       last_sample;
    } t_in;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic       positive;
        logic       significant;
        logic [8:0] confidence;
        logic [7:0] tag_a;
        logic [7:0] tag_b;
    } t_out;

    // Sealed sums handed from the accumulator to the solver.
    typedef struct packed {
        logic [CntW-1:0]        n;
        logic signed [SumW-1:0] sa;
        logic signed [SumW-1:0] sb;
        logic [SqW-1:0]         saa;
        logic [SqW-1:0]         sbb;
        logic signed [SqW-1:0]  sab;
        logic [7:0]             tag_a;
        logic [7:0]             tag_b;
    } t_job;
endpackage
`default_nettype wire

@@ hdl/pc_if.sv @@
`default_nettype none
interface pc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/pc_accum.sv @@
`default_nettype none
module pc_accum (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pc_if.sink        s_in,
    output logic      o_job_valid,
    input  wire logic i_job_ready,
    output pc_pkg::t_job o_job
);
    logic [pc_pkg::CntW-1:0]        r_n;
    logic signed [pc_pkg::SumW-1:0] r_sa, r_sb;
    logic [pc_pkg::SqW-1:0]         r_saa, r_sbb;
    logic signed [pc_pkg::SqW-1:0]  r_sab;
    logic signed [31:0] w_aa, w_bb, w_ab;
    logic w_take, w_add;
    logic [pc_pkg::CntW-1:0]        n_n;
    logic signed [pc_pkg::SumW-1:0] n_sa, n_sb;
    logic [pc_pkg::SqW-1:0]         n_saa, n_sbb;
    logic signed [pc_pkg::SqW-1:0]  n_sab;

    // Every input transfer waits until the job slot is free.
    assign s_in.ready = !o_job_valid || i_job_ready;
    assign w_take = s_in.valid && s_in.ready;
    assign w_add  = r_n < pc_pkg::CntW'(pc_pkg::SampleLimit);
    assign w_aa = s_in.data.sample_a * s_in.data.sample_a;
    assign w_bb = s_in.data.sample_b * s_in.data.sample_b;
    assign w_ab = s_in.data.sample_a * s_in.data.sample_b;

    always_comb begin
        n_n = r_n; n_sa = r_sa; n_sb = r_sb; n_saa = r_saa; n_sbb = r_sbb; n_sab = r_sab;
        if (w_add) begin
            n_n   = r_n + 1'b1;
            n_sa  = r_sa + pc_pkg::SumW'(s_in.data.sample_a);
            n_sb  = r_sb + pc_pkg::SumW'(s_in.data.sample_b);
            n_saa = r_saa + pc_pkg::SqW'($unsigned(w_aa));
            n_sbb = r_sbb + pc_pkg::SqW'($unsigned(w_bb));
            n_sab = r_sab + pc_pkg::SqW'(w_ab);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0; r_sa <= '0; r_sb <= '0; r_saa <= '0; r_sbb <= '0; r_sab <= '0;
            o_job_valid <= 1'b0;
        end else begin
            if (w_take && s_in.data.last_sample) o_job_valid <= 1'b1;
            else if (i_job_ready) o_job_valid <= 1'b0;
            if (w_take) begin
                if (s_in.data.last_sample) begin
                    o_job <= '{n_n, n_sa, n_sb, n_saa, n_sbb, n_sab,
                               s_in.data.type_a, s_in.data.type_b};
                    r_n <= '0; r_sa <= '0; r_sb <= '0;
                    r_saa <= '0; r_sbb <= '0; r_sab <= '0;
                end else begin
                    r_n <= n_n; r_sa <= n_sa; r_sb <= n_sb;
                    r_saa <= n_saa; r_sbb <= n_sbb; r_sab <= n_sab;
                end
            end
        end
    end

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= pc_pkg::CntW'(pc_pkg::SampleLimit)) else $error("count over limit");
    a_hold_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("job changed while pending");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && s_in.data.last_sample |=> r_n == '0) else $error("sums not cleared");
endmodule
`default_nettype wire

@@ hdl/pc_solve.sv @@
`default_nettype none
module pc_solve (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  pc_pkg::t_job i_job,
    input  wire logic [14:0] i_thresh,
    input  wire logic [15:0] i_min_var,
    input  wire logic [8:0]  i_full,
    pc_if.source      m_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_SRCH, S_DONE
    } t_state;

    t_state r_state;
    pc_pkg::t_job r_job;
    logic [47:0] r_sxx, r_syy;
    logic signed [47:0] r_sxy;
    logic [47:0] r_mag;
    logic r_neg, r_ok;
    logic [95:0]  r_prod;
    logic [127:0] r_num;
    logic [15:0] r_lo, r_hi;
    logic [3:0] r_mcnt;
    logic [143:0] r_acc;
    logic [31:0]  r_k2;
    logic [8:0] r_conf;
    logic [15:0] w_mid;
    logic [31:0] w_k;
    logic [24:0] w_var_n;
    // Shared 48x16 multiplier; the sxx*syy, mag*mag and prod*k*k products are summed from its partial products.
    logic [47:0] w_ma, w_src;
    logic [15:0] w_mb;
    logic [1:0]  w_seg;
    logic [6:0]  w_sh;
    logic [63:0] w_mp;

    assign o_job_ready = (r_state == S_IDLE);
    assign w_mid = 16'((17'(r_lo) + 17'(r_hi) + 17'd1) >> 1);
    assign w_k   = {15'd0, w_mid, 1'b0} - 32'd1;
    assign w_var_n = 25'(i_min_var) * 25'(r_job.n);

    always_comb begin
        w_ma  = r_sxx;
        w_src = r_syy;
        w_seg = r_mcnt[1:0];
        w_sh  = {1'b0, r_mcnt[1:0], 4'd0};
        case (r_state)
            S_M5: begin
                w_ma  = r_mag;
                w_src = r_mag;
            end
            S_SRCH: begin
                // Steps one to four pair each half of prod with each half of k*k.
                w_ma  = r_mcnt[0] ? r_prod[47:0] : r_prod[95:48];
                w_src = {16'd0, r_k2};
                w_seg = {1'b0, r_mcnt[2] | (r_mcnt[1] & r_mcnt[0])};
                w_sh  = (w_seg[0] ? 7'd16 : 7'd0) + (r_mcnt[0] ? 7'd0 : 7'd48);
            end
            default: ;
        endcase
        case (w_seg)
            2'd0:    w_mb = w_src[15:0];
            2'd1:    w_mb = w_src[31:16];
            default: w_mb = w_src[47:32];
        endcase
    end

    assign w_mp = {16'd0, w_ma} * {48'd0, w_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            m_out.valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_state <= S_M1;
                    r_mcnt <= '0;
                end
                S_M1: begin
                    // n*S - S*S for each of the three moments, all operands widened to 48 bits.
                    r_sxx <= 48'(r_job.n) * 48'(r_job.saa) - 48'(r_job.sa) * 48'(r_job.sa);
                    r_syy <= 48'(r_job.n) * 48'(r_job.sbb) - 48'(r_job.sb) * 48'(r_job.sb);
                    r_sxy <= 48'(r_job.n) * 48'(r_job.sab) - 48'(r_job.sa) * 48'(r_job.sb);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_neg <= r_sxy[47];
                    r_mag <= r_sxy[47] ? 48'(-r_sxy) : r_sxy;
                    r_ok  <= (r_job.n >= 9'd2)
                          && (r_sxx > 48'(w_var_n))
                          && (r_syy > 48'(w_var_n));
                    r_conf <= (r_job.n < 9'd2) ? 9'd0 : (r_job.n < i_full ? r_job.n : i_full);
                    r_acc <= '0; r_mcnt <= '0;
                    r_state <= S_M3;
                end
                S_M3: begin
                    // prod = sxx * syy, 16 bits of syy per cycle.
                    r_acc <= r_acc + (144'(w_mp) << w_sh);
                    if (r_mcnt == 4'd2) begin
                        r_mcnt <= '0; r_state <= S_M4;
                    end else r_mcnt <= r_mcnt + 1'b1;
                end
                S_M4: begin
                    r_prod <= r_acc[95:0];
                    r_acc <= '0;
                    r_state <= S_M5;
                end
                S_M5: begin
                    // mag * mag, 16 bits of the second factor per cycle.
                    r_acc <= r_acc + (144'(w_mp) << w_sh);
                    if (r_mcnt == 4'd2) begin
                        r_mcnt <= '0; r_state <= S_M6;
                    end else r_mcnt <= r_mcnt + 1'b1;
                end
                S_M6: begin
                    r_num <= {r_acc[95:0], 32'd0};
                    r_lo <= '0; r_hi <= 16'd32768;
                    r_mcnt <= '0;
                    r_state <= r_ok ? S_SRCH : S_DONE;
                end
                S_SRCH: begin
                    // One bisection step: test prod*k*k <= num, k*k then prod*k2 in parts.
                    if (r_mcnt == 4'd0) begin
                        if (r_lo == r_hi) r_state <= S_DONE;
                        else begin
                            r_k2 <= w_k * w_k;
                            r_acc <= '0;
                            r_mcnt <= 4'd1;
                        end
                    end else if (r_mcnt <= 4'd4) begin
                        r_acc <= r_acc + (144'(w_mp) << w_sh);
                        r_mcnt <= r_mcnt + 1'b1;
                    end else begin
                        if (r_acc <= 144'(r_num)) r_lo <= w_mid;
                        else r_hi <= w_mid - 16'd1;
                        r_mcnt <= '0;
                    end
                end
                S_DONE: if (!m_out.valid || m_out.ready) begin
                    logic [15:0] v_c;
                    v_c = !r_ok ? 16'd0 : r_neg ? 16'(-r_lo)
                        : (r_lo > 16'd32767 ? 16'd32767 : r_lo);
                    m_out.data.correlation <= v_c;
                    m_out.data.positive    <= !v_c[15] && (v_c != 16'd0);
                    m_out.data.significant <= (v_c[15] ? 16'(-v_c) : v_c) > {1'b0, i_thresh};
                    m_out.data.confidence  <= r_conf;
                    m_out.data.tag_a <= r_job.tag_a;
                    m_out.data.tag_b <= r_job.tag_b;
                    m_out.valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (m_out.valid && m_out.ready && !(r_state == S_DONE)) m_out.valid <= 1'b0;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid) else $error("result dropped");
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> r_lo <= r_hi) else $error("search bounds crossed");
    a_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.data.significant |-> m_out.data.correlation != 16'd0)
        else $error("significant flag on a zero correlation");
endmodule
`default_nettype wire

@@ hdl/pearson_correlation.sv @@
`default_nettype none
// Pearson correlation of paired signed 16-bit samples.
// Input channel s_in carries one pair, two type tags and a last marker per
// transfer; result channel m_out carries one result per sequence.
// The accumulator takes one pair per cycle unless stalled, and keeps five exact sums.
// On the last pair it hands the sums through a one-entry slot to the solver.
// The solver forms the moments, then runs a bisection of up to 16 steps for the
// Q1.15 magnitude. The sxx*syy, mag*mag and prod*k*k products are built on one
// shared 48x16 multiplier; each step forms k*k, sums prod*k*k from four partial
// products, then compares. A correlation forced to zero skips the search.
// The accumulator keeps taking pairs of the next sequence meanwhile. Once a second
// sequence is sealed while the solver is busy, input stalls until the solver takes
// it.
// A stalled receiver holds the result register and the solver.
// Reset (synchronous, active low) clears the sums, the state and restores
// register defaults: threshold 22938, minimum variance 0, full count 100.
// Configuration writes must occur only while the block is idle.
module pearson_correlation (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [pc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [pc_pkg::CfgDataW-1:0] i_cfg_data,
    pc_if.sink        s_in,
    pc_if.source      m_out
);
    logic [14:0] r_thresh;
    logic [15:0] r_min_var;
    logic [8:0]  r_full;
    logic w_jv, w_jr;
    pc_pkg::t_job w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 15'd22938; r_min_var <= '0; r_full <= 9'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pc_pkg::RegThreshold: r_thresh  <= i_cfg_data[14:0];
                pc_pkg::RegMinVar:    r_min_var <= i_cfg_data;
                pc_pkg::RegFullCount: r_full    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    pc_accum u_acc (.i_clk, .i_rst_n, .s_in, .o_job_valid(w_jv), .i_job_ready(w_jr),
                    .o_job(w_job));
    pc_solve u_slv (.i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
                    .i_thresh(r_thresh), .i_min_var(r_min_var), .i_full(r_full), .m_out);
endmodule
`default_nettype wire
